// File: rtl/core/rpe_pkg.sv
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types and constants of the run-length encoder with pair escape:
// beat payloads and the flush command passed from front to back.
// ----------------------------------------------------------------------------
package rpe_pkg;

	localparam int BYTE_W    = 8;
	localparam int RUN_LEN_W = 9;

	// queue depths between the parts
	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	// input beat
	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              last_in;
	} item_t;

	// result beat
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_out;
	} result_t;

	// one run to be written out
	typedef struct packed {
		logic [BYTE_W-1:0]    value;
		logic [RUN_LEN_W-1:0] len;
	} group_t;

	// flush command: an optional ended run, then an optional frame-final run
	typedef struct packed {
		logic   has_a;
		group_t grp_a;
		logic   has_b;
		group_t grp_b;
	} cmd_t;

	localparam int CMD_W    = $bits(cmd_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

// File: rtl/core/rpe_fifo.sv
// ----------------------------------------------------------------------------
// rpe_fifo
// Small register-based first-in first-out queue with show-ahead read.
// ----------------------------------------------------------------------------
module rpe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/rpe_front.sv
// ----------------------------------------------------------------------------
// rpe_front
// Run tracker: holds the current byte and its length, and turns each input
// beat into a flush command when a run ends or the frame closes.
// ----------------------------------------------------------------------------
module rpe_front #(
	parameter int MAX_RUN = 257
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  rpe_pkg::item_t item,
	output logic          cmd_valid,
	output rpe_pkg::cmd_t  cmd
);

	localparam logic [rpe_pkg::RUN_LEN_W-1:0] RUN_MAX = rpe_pkg::RUN_LEN_W'(MAX_RUN);
	localparam logic [rpe_pkg::RUN_LEN_W-1:0] LEN_ONE = rpe_pkg::RUN_LEN_W'(1);

	logic                            active_q;
	logic [rpe_pkg::BYTE_W-1:0]      value_q;
	logic [rpe_pkg::RUN_LEN_W-1:0]   len_q;

	logic                            has_a;
	logic [rpe_pkg::BYTE_W-1:0]      value_nx;
	logic [rpe_pkg::RUN_LEN_W-1:0]   len_nx;

	// classify the beat against the held run
	always_comb begin
		has_a    = 1'b0;
		value_nx = value_q;
		len_nx   = len_q;
		priority if (!active_q) begin
			value_nx = item.in_byte;
			len_nx   = LEN_ONE;
		end else if (item.in_byte == value_q) begin
			if (len_q >= RUN_MAX) begin
				has_a  = 1'b1;
				len_nx = LEN_ONE;
			end else begin
				len_nx = len_q + LEN_ONE;
			end
		end else begin
			has_a    = 1'b1;
			value_nx = item.in_byte;
			len_nx   = LEN_ONE;
		end
	end

	// build the flush command
	always_comb begin
		cmd.has_a       = has_a;
		cmd.grp_a.value = value_q;
		cmd.grp_a.len   = len_q;
		cmd.has_b       = item.last_in;
		cmd.grp_b.value = value_nx;
		cmd.grp_b.len   = len_nx;
	end

	assign cmd_valid = accept && (has_a || item.last_in);

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			value_q  <= '0;
			len_q    <= '0;
		end else if (accept) begin
			if (item.last_in) begin
				active_q <= 1'b0;
				value_q  <= '0;
				len_q    <= '0;
			end else begin
				active_q <= 1'b1;
				value_q  <= value_nx;
				len_q    <= len_nx;
			end
		end
	end

endmodule

// File: rtl/core/rpe_back.sv
// ----------------------------------------------------------------------------
// rpe_back
// Byte sequencer: expands each run of the flush command at the queue head
// into one literal byte or a byte pair plus length, one beat per cycle while no queue stalls it.
// ----------------------------------------------------------------------------
module rpe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_empty,
	input  rpe_pkg::cmd_t     cmd,
	output logic             cmd_pop,
	input  logic             out_full,
	output logic             out_push,
	output rpe_pkg::result_t  result
);

	localparam logic GRP_A = 1'b0;
	localparam logic GRP_B = 1'b1;

	localparam logic [1:0] IDX_FIRST = 2'd0;
	localparam logic [1:0] IDX_LEN   = 2'd2;
	localparam logic [rpe_pkg::RUN_LEN_W-1:0] LEN_ONE = rpe_pkg::RUN_LEN_W'(1);
	localparam logic [rpe_pkg::RUN_LEN_W-1:0] LEN_TWO = rpe_pkg::RUN_LEN_W'(2);

	logic                          grp_q;
	logic [1:0]                    idx_q;
	logic                          cur_grp;
	rpe_pkg::group_t               cur;
	logic [rpe_pkg::RUN_LEN_W-1:0] len_m2;
	logic                          grp_done;
	logic                          cmd_done;
	logic                          fire;

	// pick the group being written; skip an absent first group
	assign cur_grp = grp_q | !cmd.has_a;
	assign cur     = (cur_grp == GRP_B) ? cmd.grp_b : cmd.grp_a;
	assign len_m2  = cur.len - LEN_TWO;

	assign grp_done = (cur.len <= LEN_ONE) ? (idx_q == IDX_FIRST) : (idx_q == IDX_LEN);
	assign cmd_done = grp_done && ((cur_grp == GRP_B) || !cmd.has_b);
	assign fire     = !cmd_empty && !out_full;

	assign out_push = fire;
	assign cmd_pop  = fire && cmd_done;

	// result beat
	always_comb begin
		result.out_byte = (idx_q == IDX_LEN) ? len_m2[rpe_pkg::BYTE_W-1:0] : cur.value;
		result.last_out = grp_done && (cur_grp == GRP_B);
	end

	// position within the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= GRP_A;
			idx_q <= IDX_FIRST;
		end else if (fire) begin
			if (grp_done) begin
				idx_q <= IDX_FIRST;
				grp_q <= cmd_done ? GRP_A : GRP_B;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// File: rtl/core/rle_pair_escape_encoder.sv
// ----------------------------------------------------------------------------
// rle_pair_escape_encoder
// Run-length encoder with doubled-byte escape, queue interface on both sides.
// ----------------------------------------------------------------------------
// A raw byte beat is taken in any cycle in which the two-entry command queue
// has room, so input runs at one beat per cycle while runs keep growing. A run
// of one comes out as the byte alone, a longer run as the byte twice and then
// its length minus two; the byte sequencer writes one result beat per cycle
// while the result queue has room, so the result port sets the sustained rate:
// three result beats per ended run of two or more, one per single byte (one and
// a half result beats per input byte for runs of two). The command of the
// closing beat is queued, and its first result beat is queued in turn.
module rle_pair_escape_encoder #(
	parameter int MAX_RUN = 257
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rpe_pkg::item_t    item,
	output logic             empty,
	input  logic             pop,
	output rpe_pkg::result_t  result
);

	logic                          accept;
	logic                          cmd_push;
	rpe_pkg::cmd_t                 cmd_in;
	rpe_pkg::cmd_t                 cmd_head;
	logic [rpe_pkg::CMD_W-1:0]     cmd_head_bits;
	logic                          cmd_full;
	logic                          cmd_empty;
	logic                          cmd_pop;
	logic                          out_push;
	logic                          out_full;
	rpe_pkg::result_t              back_result;
	logic [rpe_pkg::RESULT_W-1:0]  out_head_bits;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// front: run tracking
	rpe_front #(
		.MAX_RUN (MAX_RUN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cmd_valid (cmd_push),
		.cmd       (cmd_in)
	);

	// command queue between front and back
	rpe_fifo #(
		.WIDTH (rpe_pkg::CMD_W),
		.DEPTH (rpe_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head_bits),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	assign cmd_head = rpe_pkg::cmd_t'(cmd_head_bits);

	// back: byte sequencing
	rpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.result    (back_result)
	);

	// result queue toward the consumer
	rpe_fifo #(
		.WIDTH (rpe_pkg::RESULT_W),
		.DEPTH (rpe_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (back_result),
		.rd_en   (pop),
		.rd_data (out_head_bits),
		.full    (out_full),
		.empty   (empty)
	);

	assign result = rpe_pkg::result_t'(out_head_bits);

	// front never pushes into a full command queue
	a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed while queue full");

	// every queued command carries at least one run
	a_cmd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (cmd_in.has_a || cmd_in.has_b))
		else $error("empty flush command queued");

	// a frame-final beat always releases its command
	a_last_pops_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && back_result.last_out) |-> cmd_pop)
		else $error("frame end without command release");

	// a beat that closes a frame produces a command
	a_last_in_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.last_in) |-> cmd_push)
		else $error("frame end produced no command");

endmodule
